// ----- rtl/correlating_branch_predictor_top_macros.svh -----
// ---------------------------------------------------------------------------
// correlating branch predictor assertion macros
// shared concurrent assertion helpers, clocked on clk with rst_n as disable
// ---------------------------------------------------------------------------
`ifndef CORRELATING_BRANCH_PREDICTOR_TOP_MACROS_SVH
`define CORRELATING_BRANCH_PREDICTOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CBP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbp assertion failed");

// next-cycle implication
`define CBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbp assertion failed");

`else

`define CBP_ASSERT_SAME(label, ante, cons)
`define CBP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/cbp_pkg.sv -----
// ---------------------------------------------------------------------------
// cbp_pkg
// constants and helper functions of the correlating branch predictor
// ---------------------------------------------------------------------------
package cbp_pkg;

    localparam int INDEX_BITS       = 14;
    localparam int MAX_COUNTER_BITS = 8;
    localparam int TABLE_DEPTH      = 1 << INDEX_BITS;
    localparam int CTR_W            = MAX_COUNTER_BITS;
    localparam int CFG_W            = 4;
    localparam int CFG_IDX_W        = 2;
    localparam int PC_W             = 32;

    // register indexes of the config port
    localparam logic [CFG_IDX_W-1:0] CFG_PC_INDEX_BITS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_BITS   = 2'd2;

    // reset values of the config registers
    localparam logic [CFG_W-1:0] RST_PC_INDEX_BITS  = 4'd10;
    localparam logic [CFG_W-1:0] RST_HISTORY_LENGTH = 4'd4;
    localparam logic [CFG_W-1:0] RST_COUNTER_BITS   = 4'd2;

    typedef logic [INDEX_BITS-1:0] idx_t;
    typedef logic [CTR_W-1:0]      ctr_t;

    // index width limited to the table index
    function automatic idx_t width_mask(input logic [CFG_W-1:0] w);
        idx_t m;
        for (int i = 0; i < INDEX_BITS; i++)
        begin
            m[i] = (i < int'(w));
        end
        return m;
    endfunction

    // all-ones counter value for the effective counter width
    function automatic ctr_t counter_max(input logic [CFG_W-1:0] nb);
        ctr_t m;
        int   eff;
        eff = int'(nb);
        if (eff < 1)
        begin
            eff = 1;
        end
        if (eff > MAX_COUNTER_BITS)
        begin
            eff = MAX_COUNTER_BITS;
        end
        for (int i = 0; i < CTR_W; i++)
        begin
            m[i] = (i < eff);
        end
        return m;
    endfunction

    // shift amount for the pc part, saturated at the index width
    function automatic int clamp_shift(input logic [CFG_W-1:0] w);
        return (int'(w) > INDEX_BITS) ? INDEX_BITS : int'(w);
    endfunction

endpackage

// ----- rtl/cbp_ram.sv -----
// ---------------------------------------------------------------------------
// cbp_ram
// generic one-write one-read ram with registered read data
// ---------------------------------------------------------------------------
module cbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds when no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/correlating_branch_predictor_top.sv -----
// ---------------------------------------------------------------------------
// correlating_branch_predictor_top: gselect predictor over one counter ram
// each word takes a ram read, then a counter update and write back on a train; a
// prediction waits in the lookup state while the output register stays full
// a prediction goes from the lookup state into the output register
// reset runs a clearing pass over all 2^INDEX_BITS (16384) entries before any word
// ---------------------------------------------------------------------------
`include "correlating_branch_predictor_top_macros.svh"

module correlating_branch_predictor_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // config port
    input  logic                          cfg_we,
    input  logic [cbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cbp_pkg::CFG_W-1:0]     cfg_data,
    // request channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          req_type,
    input  logic [cbp_pkg::PC_W-1:0]      pc,
    input  logic                          outcome,
    // prediction channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          taken
);

    // controller states: clearing pass, waiting for a word, ram data back
    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_LOOKUP = 2'd2;

    logic [1:0]                     state_reg, state_next;
    cbp_pkg::idx_t                  clr_cnt_reg, clr_cnt_next;
    cbp_pkg::idx_t                  hist_reg, hist_next;
    cbp_pkg::idx_t                  idx_reg, idx_next;
    logic                           req_reg, req_next;
    logic                           outcome_reg, outcome_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           taken_reg, taken_next;
    logic [cbp_pkg::CFG_W-1:0]      pc_index_bits_reg;
    logic [cbp_pkg::CFG_W-1:0]      history_length_reg;
    logic [cbp_pkg::CFG_W-1:0]      counter_bits_reg;

    // ram side
    logic                           ram_we;
    cbp_pkg::idx_t                  ram_waddr;
    cbp_pkg::ctr_t                  ram_wdata;
    logic                           ram_re;
    cbp_pkg::idx_t                  ram_raddr;
    cbp_pkg::ctr_t                  ram_rdata;

    logic                           in_fire;
    cbp_pkg::idx_t                  lookup_idx;
    cbp_pkg::idx_t                  hist_keep;
    cbp_pkg::ctr_t                  ctr_max;
    cbp_pkg::ctr_t                  ctr_upd;

    // ------------------------------------------------------------------
    // counter table: one ram, read on accept; on a train, written back in the next cycle, no later
    // ------------------------------------------------------------------
    cbp_ram #(
        .WIDTH (cbp_pkg::CTR_W),
        .DEPTH (cbp_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // one word in flight at a time, so a write back always lands before the
    // next word reads the ram; no forwarding path is needed
    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    // gselect index: masked pc bits above the masked history bits, cut to
    // the table width (the shift drops anything past the top)
    assign hist_keep  = cbp_pkg::width_mask(history_length_reg);
    assign lookup_idx = ((pc[cbp_pkg::INDEX_BITS-1:0]
                          & cbp_pkg::width_mask(pc_index_bits_reg))
                         << cbp_pkg::clamp_shift(history_length_reg))
                        | (hist_reg & hist_keep);

    assign ram_re    = in_fire;
    assign ram_raddr = lookup_idx;

    // saturating update; a counter left above the maximum by a narrower
    // counter width holds on taken and steps down on not taken
    assign ctr_max = cbp_pkg::counter_max(counter_bits_reg);

    always_comb
    begin
        ctr_upd = ram_rdata;
        if (outcome_reg)
        begin
            if (ram_rdata < ctr_max)
            begin
                ctr_upd = ram_rdata + cbp_pkg::ctr_t'(1);
            end
        end
        else
        begin
            if (ram_rdata != '0)
            begin
                ctr_upd = ram_rdata - cbp_pkg::ctr_t'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // controller
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        hist_next      = hist_reg;
        idx_next       = idx_reg;
        req_next       = req_reg;
        outcome_next   = outcome_reg;
        out_valid_next = out_valid_reg;
        taken_next     = taken_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = ctr_upd;

        // output register drains independently of the controller
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // zero one entry per cycle
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + cbp_pkg::idx_t'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    idx_next     = lookup_idx;
                    req_next     = req_type;
                    outcome_next = outcome;
                    state_next   = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (req_reg)
                begin
                    // train: write the counter back and shift the history
                    ram_we     = 1'b1;
                    hist_next  = ((hist_reg << 1)
                                  | cbp_pkg::idx_t'(outcome_reg)) & hist_keep;
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    // predict: taken at or above half range; the ram output
                    // holds while the output register is still full
                    out_valid_next = 1'b1;
                    taken_next     = (ram_rdata > (ctr_max >> 1));
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            hist_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            hist_reg      <= hist_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        req_reg     <= req_next;
        outcome_reg <= outcome_next;
        taken_reg   <= taken_next;
    end

    // config registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_index_bits_reg  <= cbp_pkg::RST_PC_INDEX_BITS;
            history_length_reg <= cbp_pkg::RST_HISTORY_LENGTH;
            counter_bits_reg   <= cbp_pkg::RST_COUNTER_BITS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cbp_pkg::CFG_PC_INDEX_BITS:  pc_index_bits_reg  <= cfg_data;
                cbp_pkg::CFG_HISTORY_LENGTH: history_length_reg <= cfg_data;
                cbp_pkg::CFG_COUNTER_BITS:   counter_bits_reg   <= cfg_data;
                default:                     ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign taken     = taken_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `CBP_ASSERT_NEXT(a_accept_to_lookup, in_valid && in_ready, state_reg == ST_LOOKUP)
    `CBP_ASSERT_NEXT(a_train_one_cycle, (state_reg == ST_LOOKUP) && req_reg, state_reg == ST_IDLE)
    `CBP_ASSERT_SAME(a_no_result_in_clear, state_reg == ST_CLEAR, !out_valid_reg && !in_ready)
    `CBP_ASSERT_NEXT(a_result_only_from_predict, !out_valid_reg && out_valid_next, (state_reg == ST_IDLE) && !$past(req_reg))

endmodule
